// File: hw/rtl/complex_magnitude_isqrt_unit_defines.svh
// Assertion macros shared by the complex magnitude unit.
`ifndef COMPLEX_MAGNITUDE_ISQRT_UNIT_DEFINES_SVH
`define COMPLEX_MAGNITUDE_ISQRT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CMISQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cmisq: same-cycle check failed");

// Implication whose consequent may carry a fixed delay or a history term.
`define CMISQ_ASSERT_LATER(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("cmisq: timing check failed");

`endif

// File: hw/rtl/cmisq_pkg.sv
// Package with shared types and constants of the complex magnitude unit.
`timescale 1ns / 1ps
package cmisq_pkg;

    localparam int MAG_WIDTH = 16;

    typedef logic [MAG_WIDTH-1:0] t_magnitude;

    // Control that travels with each pipeline slot.
    typedef struct packed {
        logic valid;
    } t_cmisq_ctrl;

endpackage

// File: hw/rtl/complex_magnitude_isqrt_unit.sv
// Top level of the complex magnitude unit: |re + j*im| by pipelined integer square root.
`timescale 1ns / 1ps
//
//  channel   ports                               direction  handshake
//  --------  ----------------------------------  ---------  -------------------------------
//  command   i_start, i_real_part, i_imag_part   in         taken when i_start && !o_busy
//  result    o_valid, o_magnitude                out        one-cycle strobe, no back-pressure
//
//  One transaction enters per clock; o_busy stays low, so the unit never refuses a command.
//  Registered stages: absolute value, squaring, sum, then one register
//  stage per root bit (SAMPLE_WIDTH restoring steps, each one wide add and compare).
//  Reset (synchronous, active low) clears only the valid bits; in-flight data is dropped.
//  Results cannot be stalled, so the pipeline simply advances every cycle.
//
`include "complex_magnitude_isqrt_unit_defines.svh"
module complex_magnitude_isqrt_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_real_part,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_imag_part,
    output logic                            o_valid,
    output cmisq_pkg::t_magnitude           o_magnitude
);
    import cmisq_pkg::*;

    localparam int SQ_WIDTH = 2 * SAMPLE_WIDTH;
    localparam int LATENCY  = SAMPLE_WIDTH + 3;

    // Front stages: absolute value, square, sum of squares.
    t_cmisq_ctrl             r_abs_ctrl;
    logic [SAMPLE_WIDTH-1:0] r_re_abs;
    logic [SAMPLE_WIDTH-1:0] r_im_abs;
    logic [SAMPLE_WIDTH-1:0] n_re_abs;
    logic [SAMPLE_WIDTH-1:0] n_im_abs;

    t_cmisq_ctrl             r_sq_ctrl;
    logic [SQ_WIDTH-1:0]     r_re_sq;
    logic [SQ_WIDTH-1:0]     r_im_sq;

    t_cmisq_ctrl             r_sum_ctrl;
    logic [SQ_WIDTH-1:0]     r_sum;

    // Root pipeline taps; index 0 is the sum stage, index SAMPLE_WIDTH the last step.
    t_cmisq_ctrl             root_ctrl [SAMPLE_WIDTH+1];
    logic [SQ_WIDTH-1:0]     root_rem  [SAMPLE_WIDTH+1];
    logic [SQ_WIDTH-1:0]     root_acc  [SAMPLE_WIDTH+1];

    t_cmisq_ctrl             in_ctrl;

    assign o_busy        = 1'b0;
    assign in_ctrl.valid = i_start;

    // Magnitude of each part; the most negative code maps to 2^(SAMPLE_WIDTH-1),
    // which still fits unsigned in SAMPLE_WIDTH bits.
    always_comb begin
        n_re_abs = i_real_part[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - $unsigned(i_real_part))
                                               : $unsigned(i_real_part);
        n_im_abs = i_imag_part[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - $unsigned(i_imag_part))
                                               : $unsigned(i_imag_part);
    end

    // Valid bits: clear on reset, otherwise advance every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_ctrl.valid <= 1'b0;
            r_sq_ctrl.valid  <= 1'b0;
            r_sum_ctrl.valid <= 1'b0;
        end else begin
            r_abs_ctrl <= in_ctrl;
            r_sq_ctrl  <= r_abs_ctrl;
            r_sum_ctrl <= r_sq_ctrl;
        end
    end

    // Payload: the sum of two squares is at most 2^(2*SAMPLE_WIDTH-1), so it never wraps.
    always_ff @(posedge i_clk) begin
        r_re_abs <= n_re_abs;
        r_im_abs <= n_im_abs;
        r_re_sq  <= SQ_WIDTH'(r_re_abs) * SQ_WIDTH'(r_re_abs);
        r_im_sq  <= SQ_WIDTH'(r_im_abs) * SQ_WIDTH'(r_im_abs);
        r_sum    <= r_re_sq + r_im_sq;
    end

    assign root_ctrl[0] = r_sum_ctrl;
    assign root_rem[0]  = r_sum;
    assign root_acc[0]  = '0;

    // One registered step per root bit, test place moving down by two bits each step.
    for (genvar g = 0; g < SAMPLE_WIDTH; g++) begin : g_root
        cmisq_root_stage #(
            .WIDTH (SQ_WIDTH),
            .STEP  (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (root_ctrl[g]),
            .i_rem   (root_rem[g]),
            .i_acc   (root_acc[g]),
            .o_ctrl  (root_ctrl[g+1]),
            .o_rem   (root_rem[g+1]),
            .o_acc   (root_acc[g+1])
        );
    end

    // The last step's register is the output register; keep the low magnitude bits.
    assign o_valid     = root_ctrl[SAMPLE_WIDTH].valid;
    assign o_magnitude = MAG_WIDTH'(root_acc[SAMPLE_WIDTH]);

    // Every accepted command yields a matching result strobe.
    `CMISQ_ASSERT_LATER(a_start_to_result, i_start && !o_busy, ##LATENCY o_valid)
    // No strobe without a matching earlier command.
    `CMISQ_ASSERT_LATER(a_result_has_start, o_valid, $past(i_start, LATENCY))
    // Floor property of the root: leftover remainder never exceeds twice the root.
    `CMISQ_ASSERT_IMPLIES(a_root_floor, o_valid,
        root_rem[SAMPLE_WIDTH] <= (root_acc[SAMPLE_WIDTH] << 1))

endmodule

// File: hw/rtl/cmisq_root_stage.sv
// One restoring square-root step: decide one root bit and register the result.
`timescale 1ns / 1ps
module cmisq_root_stage #(
    parameter int WIDTH = 32,
    parameter int STEP  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cmisq_pkg::t_cmisq_ctrl i_ctrl,
    input  logic [WIDTH-1:0]      i_rem,
    input  logic [WIDTH-1:0]      i_acc,
    output cmisq_pkg::t_cmisq_ctrl o_ctrl,
    output logic [WIDTH-1:0]      o_rem,
    output logic [WIDTH-1:0]      o_acc
);
    import cmisq_pkg::*;

    // Test place for this step: 4^(WIDTH/2 - 1 - STEP).
    localparam logic [WIDTH:0] BITPOS = (WIDTH+1)'(1) << (WIDTH - 2 - 2 * STEP);

    t_cmisq_ctrl      r_ctrl;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH:0]   trial;

    always_comb begin
        trial = {1'b0, i_acc} + BITPOS;
        if ({1'b0, i_rem} >= trial) begin
            n_rem = i_rem - trial[WIDTH-1:0];
            n_acc = (i_acc >> 1) + BITPOS[WIDTH-1:0];
        end else begin
            n_rem = i_rem;
            n_acc = i_acc >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    // Payload needs no reset; it is qualified by the valid bit.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_acc <= n_acc;
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;

endmodule
